// File: design/text_console_writer_top_assert.svh
// assertion macros for the console writer
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tcw assertion failed");
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcw sequence assertion failed");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/tcw_pkg.sv
package tcw_pkg;

    // opcodes of a request
    localparam logic [2:0] OPC_PUT    = 3'd0;
    localparam logic [2:0] OPC_WRITE  = 3'd1;
    localparam logic [2:0] OPC_SETCUR = 3'd2;
    localparam logic [2:0] OPC_READ   = 3'd3;
    localparam logic [2:0] OPC_CLEAR  = 3'd4;

    localparam logic [7:0] NEWLINE_CODE     = 8'd10;
    localparam logic [7:0] SPACE_CODE       = 8'd32;
    localparam logic [7:0] RESET_BLANK_ATTR = 8'd7;

    // classified operation kinds
    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_WRITE,
        K_SETCUR,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        ignored;
        logic [7:0]  ch;
        logic [7:0]  at;
        logic [6:0]  col;
        logic [4:0]  row;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL
    } t_state;

endpackage

// File: design/tcw_if.sv
interface tcw_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] character;
    logic [7:0] attribute;
    logic [6:0] column;
    logic [4:0] row;
    modport source(output valid, opcode, character, attribute, column, row, input ready);
    modport sink(input valid, opcode, character, attribute, column, row, output ready);
endinterface

interface tcw_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic [7:0] cell_character;
    logic [7:0] cell_attribute;
    logic       position_ignored;
    modport source(output valid, cursor_column, cursor_row, cell_character,
                   cell_attribute, position_ignored, input ready);
    modport sink(input valid, cursor_column, cursor_row, cell_character,
                 cell_attribute, position_ignored, output ready);
endinterface

// File: design/tcw_front.sv
module tcw_front #(
    parameter int COLUMN_COUNT = 80,
    parameter int ROW_COUNT    = 25
) (
    tcw_in_if.sink          i_cmd,
    input  tcw_pkg::t_q_stat i_q_stat,
    output tcw_pkg::t_push   o_push
);
    localparam logic [7:0] COLS_W = 8'(COLUMN_COUNT);
    localparam logic [5:0] ROWS_W = 6'(ROW_COUNT);

    logic in_range;

    // accept whenever the queue has room
    assign i_cmd.ready  = !i_q_stat.full;
    assign o_push.valid = i_cmd.valid && !i_q_stat.full;

    assign in_range = ({1'b0, i_cmd.column} < COLS_W) && ({1'b0, i_cmd.row} < ROWS_W);

    // classify the request
    always_comb begin
        o_push.cmd.ch      = i_cmd.character;
        o_push.cmd.at      = i_cmd.attribute;
        o_push.cmd.col     = i_cmd.column;
        o_push.cmd.row     = i_cmd.row;
        o_push.cmd.ignored = 1'b0;
        o_push.cmd.kind    = tcw_pkg::K_NOP;
        unique case (i_cmd.opcode)
            tcw_pkg::OPC_PUT: begin
                o_push.cmd.kind = (i_cmd.character == tcw_pkg::NEWLINE_CODE) ?
                                  tcw_pkg::K_NEWLINE : tcw_pkg::K_PUT;
            end
            tcw_pkg::OPC_WRITE: begin
                o_push.cmd.kind    = tcw_pkg::K_WRITE;
                o_push.cmd.ignored = !in_range;
            end
            tcw_pkg::OPC_SETCUR: begin
                o_push.cmd.kind    = tcw_pkg::K_SETCUR;
                o_push.cmd.ignored = !in_range;
            end
            tcw_pkg::OPC_READ: begin
                o_push.cmd.kind    = tcw_pkg::K_READ;
                o_push.cmd.ignored = !in_range;
            end
            tcw_pkg::OPC_CLEAR: begin
                o_push.cmd.kind = tcw_pkg::K_CLEAR;
            end
            default: begin
                o_push.cmd.kind = tcw_pkg::K_NOP;
            end
        endcase
    end
endmodule

// File: design/tcw_queue.sv
module tcw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcw_pkg::t_push   i_push,
    input  logic             i_pop,
    output tcw_pkg::t_cmd    o_cmd,
    output tcw_pkg::t_q_stat o_stat
);
    tcw_pkg::t_cmd r_slot [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          n_wptr;
    logic          n_rptr;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_slot[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = do_push ? !r_wptr : r_wptr;
        n_rptr  = do_pop ? !r_rptr : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_push.cmd;
        end
    end
endmodule

// File: design/tcw_back.sv
`include "text_console_writer_top_assert.svh"

module tcw_back #(
    parameter int COLUMN_COUNT = 80,
    parameter int ROW_COUNT    = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_blank_attr,
    input  tcw_pkg::t_cmd    i_cmd,
    input  tcw_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    tcw_out_if.source        o_res
);
    localparam int TOTAL = COLUMN_COUNT * ROW_COUNT;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [AW-1:0] LAST_IDX   = AW'(TOTAL - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(TOTAL - COLUMN_COUNT - 1);
    localparam logic [AW-1:0] COL_STEP   = AW'(COLUMN_COUNT);
    localparam logic [7:0]    COLS_W     = 8'(COLUMN_COUNT);
    localparam logic [5:0]    ROWS_W     = 6'(ROW_COUNT);
    localparam logic [4:0]    ROW_LAST   = 5'(ROW_COUNT - 1);

    logic [15:0] r_mem [TOTAL];
    logic [15:0] r_rdata;

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;
    logic [AW-1:0]   r_idx;
    logic [AW-1:0]   n_idx;
    logic [6:0]      r_cur_col;
    logic [6:0]      n_cur_col;
    logic [4:0]      r_cur_row;
    logic [4:0]      n_cur_row;
    logic [7:0]      r_blank;
    logic [7:0]      n_blank;
    logic            r_out_valid;

    logic            can_go;
    logic [7:0]      col_inc;
    logic [6:0]      adv_col;
    logic [5:0]      adv_row;
    logic            scroll_need;
    logic [AW-1:0]   cur_addr;
    logic [AW-1:0]   cmd_addr;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [15:0]     mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra;
    logic            fin;
    logic [7:0]      fin_ch;
    logic [7:0]      fin_at;
    logic            fin_ign;

    // a request starts only when the result slot will be free
    assign can_go   = !i_q_stat.empty && (!r_out_valid || o_res.ready);
    assign cur_addr = AW'(r_cur_row * COLUMN_COUNT + r_cur_col);
    assign cmd_addr = AW'(i_cmd.row * COLUMN_COUNT + i_cmd.col);

    // cursor advance for put char and newline
    always_comb begin
        col_inc = {1'b0, r_cur_col} + 8'd1;
        if (i_cmd.kind == tcw_pkg::K_NEWLINE || col_inc == COLS_W) begin
            adv_col = 7'd0;
            adv_row = {1'b0, r_cur_row} + 6'd1;
        end else begin
            adv_col = col_inc[6:0];
            adv_row = {1'b0, r_cur_row};
        end
        scroll_need = (adv_row == ROWS_W);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                if (r_idx == LAST_IDX) n_state = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (can_go) begin
                    case (i_cmd.kind)
                        tcw_pkg::K_PUT, tcw_pkg::K_NEWLINE: begin
                            if (scroll_need) n_state = tcw_pkg::ST_SCROLL_RD;
                        end
                        tcw_pkg::K_READ: begin
                            if (!i_cmd.ignored) n_state = tcw_pkg::ST_READ;
                        end
                        tcw_pkg::K_CLEAR: n_state = tcw_pkg::ST_FILL;
                        default: n_state = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_READ:      n_state = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_SCROLL_RD: n_state = tcw_pkg::ST_SCROLL_WR;
            tcw_pkg::ST_SCROLL_WR: begin
                n_state = (r_idx == SCROLL_END) ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCROLL_RD;
            end
            tcw_pkg::ST_FILL: begin
                if (r_idx == LAST_IDX) n_state = tcw_pkg::ST_IDLE;
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    // datapath controls per state
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = r_idx;
        mem_wd    = {r_blank, tcw_pkg::SPACE_CODE};
        mem_re    = 1'b0;
        mem_ra    = cmd_addr;
        o_pop     = 1'b0;
        n_idx     = r_idx;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_blank   = r_blank;
        fin       = 1'b0;
        fin_ch    = 8'd0;
        fin_at    = 8'd0;
        fin_ign   = 1'b0;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                if (can_go) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        tcw_pkg::K_PUT, tcw_pkg::K_NEWLINE: begin
                            if (i_cmd.kind == tcw_pkg::K_PUT) begin
                                mem_we = 1'b1;
                                mem_wa = cur_addr;
                                mem_wd = {i_cmd.at, i_cmd.ch};
                            end
                            n_cur_col = adv_col;
                            if (scroll_need) begin
                                n_cur_row = ROW_LAST;
                                n_idx     = '0;
                                n_blank   = i_blank_attr;
                            end else begin
                                n_cur_row = adv_row[4:0];
                                fin       = 1'b1;
                            end
                        end
                        tcw_pkg::K_WRITE: begin
                            mem_we  = !i_cmd.ignored;
                            mem_wa  = cmd_addr;
                            mem_wd  = {i_cmd.at, i_cmd.ch};
                            fin     = 1'b1;
                            fin_ign = i_cmd.ignored;
                        end
                        tcw_pkg::K_SETCUR: begin
                            if (!i_cmd.ignored) begin
                                n_cur_col = i_cmd.col;
                                n_cur_row = i_cmd.row;
                            end
                            fin     = 1'b1;
                            fin_ign = i_cmd.ignored;
                        end
                        tcw_pkg::K_READ: begin
                            if (i_cmd.ignored) begin
                                fin     = 1'b1;
                                fin_ign = 1'b1;
                            end else begin
                                mem_re = 1'b1;
                            end
                        end
                        tcw_pkg::K_CLEAR: begin
                            n_cur_col = 7'd0;
                            n_cur_row = 5'd0;
                            n_idx     = '0;
                            n_blank   = i_blank_attr;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                fin    = 1'b1;
                fin_ch = r_rdata[7:0];
                fin_at = r_rdata[15:8];
            end
            tcw_pkg::ST_SCROLL_RD: begin
                mem_re = 1'b1;
                mem_ra = r_idx + COL_STEP;
            end
            tcw_pkg::ST_SCROLL_WR: begin
                mem_we = 1'b1;
                mem_wd = r_rdata;
                n_idx  = r_idx + 1'b1;
            end
            tcw_pkg::ST_FILL: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                fin    = (r_idx == LAST_IDX);
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_idx       <= '0;
            r_cur_col   <= 7'd0;
            r_cur_row   <= 5'd0;
            r_blank     <= tcw_pkg::RESET_BLANK_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_blank   <= n_blank;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fin) begin
            o_res.cursor_column    <= n_cur_col;
            o_res.cursor_row       <= n_cur_row;
            o_res.cell_character   <= fin_ch;
            o_res.cell_attribute   <= fin_at;
            o_res.position_ignored <= fin_ign;
        end
    end

    assign o_res.valid = r_out_valid;

    // screen store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    `TCW_ASSERT(a_cur_row_range, {1'b0, r_cur_row} < ROWS_W)
    `TCW_ASSERT(a_cur_col_range, {1'b0, r_cur_col} < COLS_W)
    `TCW_ASSERT(a_pop_only_idle, !o_pop || r_state == tcw_pkg::ST_IDLE)
    `TCW_ASSERT(a_fin_slot_free, !fin || !r_out_valid || o_res.ready)
    `TCW_ASSERT_NEXT(a_scroll_pair, r_state == tcw_pkg::ST_SCROLL_RD, r_state == tcw_pkg::ST_SCROLL_WR)
endmodule

// File: design/text_console_writer_top.sv
// text-mode console store with cursor, one request per operation
// i_cmd carries opcode, character, attribute, column and row on a
// valid/ready handshake; o_res returns one result per request with the
// cursor after the operation, the cell read by read cell and the flag for
// an out-of-range position. i_cfg_we/i_cfg_wdata write the blank attribute
// used by scroll and clear.
// a two-entry queue sits between the classifier and the executing sequencer;
// the sequencer starts one request at a time from the queue head.
// put char, write, set cursor and ignored positions register their result
// as the request leaves the queue; read cell first reads the store word.
// clear walks every cell; a put char that runs off the last row scrolls
// with one read and one write per moved cell, as the store has one write
// and one read port.
// after reset the store is filled with blanks in attribute 7, one cell per
// cycle; requests wait in the queue meanwhile.
// a stalled o_res holds its result; the queue keeps taking requests until full.
module text_console_writer_top #(
    parameter int COLUMN_COUNT = 80,
    parameter int ROW_COUNT    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    tcw_in_if.sink     i_cmd,
    tcw_out_if.source  o_res
);
    logic [7:0]       r_blank_attr;
    tcw_pkg::t_push   push;
    tcw_pkg::t_cmd    q_cmd;
    tcw_pkg::t_q_stat q_stat;
    logic             pop;

    // blank attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= tcw_pkg::RESET_BLANK_ATTR;
        end else if (i_cfg_we) begin
            r_blank_attr <= i_cfg_wdata;
        end
    end

    tcw_front #(
        .COLUMN_COUNT(COLUMN_COUNT),
        .ROW_COUNT   (ROW_COUNT)
    ) u_front (
        .i_cmd   (i_cmd),
        .i_q_stat(q_stat),
        .o_push  (push)
    );

    tcw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_cmd  (q_cmd),
        .o_stat (q_stat)
    );

    tcw_back #(
        .COLUMN_COUNT(COLUMN_COUNT),
        .ROW_COUNT   (ROW_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blank_attr(r_blank_attr),
        .i_cmd       (q_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_res       (o_res)
    );
endmodule
